[hw/rtl/pmd_pkg.sv]
// Shared types and constants for the PS/2 mouse packet decoder.
`timescale 1ns / 1ps
`default_nettype none
package pmd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST = 13'd480;

  // Flag byte bit positions.
  localparam int unsigned FLAG_SYNC_BIT = 3;
  localparam int unsigned FLAG_XSIGN_BIT = 4;
  localparam int unsigned FLAG_YSIGN_BIT = 5;
  localparam int unsigned FLAG_XOVF_BIT = 6;
  localparam int unsigned FLAG_YOVF_BIT = 7;

  typedef enum logic [1:0] {
    POS_FLAG = 2'd0,
    POS_X    = 2'd1,
    POS_Y    = 2'd2
  } byte_pos_t;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [BTN_W-1:0]   buttons;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/pmd_in_reg.sv]
// Input register that holds one received byte until the decoder consumes it.
`timescale 1ns / 1ps
`default_nettype none
module pmd_in_reg
  import pmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              advance,
  output logic                   byte_vld,
  output logic [BYTE_W-1:0]      byte_data
);

  logic              vld_r;
  logic [BYTE_W-1:0] data_r;
  logic              take;

  assign in_stall  = vld_r & ~advance;
  assign take      = in_valid & ~in_stall;
  assign byte_vld  = vld_r;
  assign byte_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_byte;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pmd_decode.sv]
// Packet assembly state and cursor update with clamping to the screen.
`timescale 1ns / 1ps
`default_nettype none
module pmd_decode
  import pmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] byte_data,
  input  wire logic [SIZE_W-1:0] screen_width,
  input  wire logic [SIZE_W-1:0] screen_height,
  output logic                   emit,
  output result_t                res
);

  localparam int unsigned SUM_W = COORD_W + 2;

  byte_pos_t           pos_r, pos_nxt;
  logic [BYTE_W-1:0]   flag_r, flag_nxt;
  logic [BYTE_W-1:0]   xb_r, xb_nxt;
  logic [COORD_W-1:0]  pos_x_r, pos_x_nxt;
  logic [COORD_W-1:0]  pos_y_r, pos_y_nxt;
  logic                upd;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [COORD_W-1:0]  new_x;
  logic [COORD_W-1:0]  new_y;

  // Largest legal coordinate: a size of zero acts as one, above 4096 as 4096.
  function automatic logic [COORD_W-1:0] max_coord(input logic [SIZE_W-1:0] size);
    logic [COORD_W-1:0] m;
    if (size[SIZE_W-1]) begin
      m = '1;
    end else if (size == '0) begin
      m = '0;
    end else begin
      m = size[COORD_W-1:0] - COORD_W'(1);
    end
    return m;
  endfunction

  function automatic logic [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                               input logic [COORD_W-1:0] lim);
    logic [COORD_W-1:0] c;
    if (v[SUM_W-1]) begin
      c = '0;
    end else if (v[SUM_W-2:0] > {1'b0, lim}) begin
      c = lim;
    end else begin
      c = v[COORD_W-1:0];
    end
    return c;
  endfunction

  assign sum_x = $signed({2'b00, pos_x_r})
               + $signed({{(SUM_W-BYTE_W){flag_r[FLAG_XSIGN_BIT]}}, xb_r});
  assign sum_y = $signed({2'b00, pos_y_r})
               - $signed({{(SUM_W-BYTE_W){flag_r[FLAG_YSIGN_BIT]}}, byte_data});
  assign new_x = clamp(sum_x, max_coord(screen_width));
  assign new_y = clamp(sum_y, max_coord(screen_height));

  // A completed packet counts only when neither overflow bit is set.
  assign emit = (pos_r == POS_Y) & ~flag_r[FLAG_XOVF_BIT] & ~flag_r[FLAG_YOVF_BIT];
  assign upd  = advance & emit;

  assign res.cursor_x = new_x;
  assign res.cursor_y = new_y;
  assign res.buttons  = flag_r[BTN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_FLAG;
      flag_r  <= '0;
      xb_r    <= '0;
      pos_x_r <= SCREEN_W_RST[COORD_W:1];
      pos_y_r <= SCREEN_H_RST[COORD_W:1];
    end else begin
      pos_r   <= pos_nxt;
      flag_r  <= flag_nxt;
      xb_r    <= xb_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    flag_nxt  = flag_r;
    xb_nxt    = xb_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (advance) begin
      unique case (pos_r)
        POS_X: begin
          xb_nxt  = byte_data;
          pos_nxt = POS_Y;
        end
        POS_Y: begin
          pos_nxt = POS_FLAG;
        end
        default: begin
          // Without the sync bit the byte cannot start a packet; drop it.
          if (byte_data[FLAG_SYNC_BIT]) begin
            flag_nxt = byte_data;
            pos_nxt  = POS_X;
          end else begin
            pos_nxt  = POS_FLAG;
          end
        end
      endcase
    end
    if (upd) begin
      pos_x_nxt = new_x;
      pos_y_nxt = new_y;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pmd_out_reg.sv]
// Result register that holds one cursor beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module pmd_out_reg
  import pmd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res,
  output logic         can_take,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res
);

  logic    vld_r;
  result_t data_r;

  assign can_take  = ~vld_r | ~out_stall;
  assign out_valid = vld_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ps2_mouse_packet_decoder.sv]
// Top level of the PS/2 mouse packet decoder.
// Takes one mouse byte per beat and, for each valid three-byte packet, emits the
// clamped cursor position and the button bits. A byte is accepted every cycle
// at full rate: it is registered at the input, then decoded and applied to the
// cursor, and the result is held in an output register. Only a third byte that
// finds the output register full and stalled has to wait, and the input stalls
// behind it. Resync bytes, the first two bytes of a packet and overflowed
// packets produce no beat. The cursor starts at the centre of the 640 by 480
// reset screen. The user must write the screen size registers through the cfg
// port (always ready) only while the block is idle; the block does not enforce
// this itself.
`timescale 1ns / 1ps
`default_nettype none
module ps2_mouse_packet_decoder
  import pmd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COORD_W-1:0]        out_cursor_x,
  output logic [COORD_W-1:0]        out_cursor_y,
  output logic [BTN_W-1:0]          out_buttons,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] screen_width_r;
  logic [SIZE_W-1:0] screen_height_r;
  logic              byte_vld;
  logic [BYTE_W-1:0] byte_data;
  logic              advance;
  logic              emit;
  logic              can_take;
  result_t           res;
  result_t           out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_W_RST;
      screen_height_r <= SCREEN_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held byte moves on unless it completes a packet and the output register is full and stalled.
  assign advance = byte_vld & (~emit | can_take);

  pmd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_rx_byte),
    .advance   (advance),
    .byte_vld  (byte_vld),
    .byte_data (byte_data)
  );

  pmd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .byte_data     (byte_data),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .emit          (emit),
    .res           (res)
  );

  pmd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance & emit),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_cursor_x = out_res.cursor_x;
  assign out_cursor_y = out_res.cursor_y;
  assign out_buttons  = out_res.buttons;

endmodule
`default_nettype wire

[bench/tb_ps2_mouse_packet_decoder.sv]
// Self-checking testbench for the PS/2 mouse packet decoder: packet tracking, clamping, flow control.
`timescale 1ns / 1ps
module tb_ps2_mouse_packet_decoder;
  import pmd_pkg::*;

  localparam int CLK_HIGH = 6;
  localparam int CLK_LOW = 6;
  localparam int RESET_CYCLES = 6;
  // Margin to wait once every expected result has been seen.
  localparam int SETTLE_CYCLES = 6;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int MAX_SCREEN = 1 << COORD_W;
  localparam int CFG_DATA_MAX = (1 << SIZE_W) - 1;
  localparam int HOLD_CYCLES = 80;
  localparam logic [10:0] STALL_PATTERN_BITS = 11'b01101001110;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COORD_W-1:0] out_cursor_x;
  logic [COORD_W-1:0] out_cursor_y;
  logic [BTN_W-1:0] out_buttons;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // Expected cursor updates, oldest first.
  result_t pending_moves[$];

  // Tracked decoder state.
  byte_pos_t pkt_pos;
  logic [BYTE_W-1:0] pkt_flag;
  logic [BYTE_W-1:0] pkt_xlow;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  int err_count = 0;
  int bytes_sent = 0;
  int moves_predicted = 0;
  int moves_checked = 0;
  int resync_drops = 0;
  int overflow_drops = 0;
  int screens_used = 0;

  // Sender burst state and receiver controls.
  bit gaps_on = 1'b1;
  int burst_left = 0;
  stall_mode_t stall_mode = STALL_OFF;
  int hold_req = 0;
  int hold_left = 0;
  int pattern_step = 0;

  ps2_mouse_packet_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cursor_x(out_cursor_x),
    .out_cursor_y(out_cursor_y),
    .out_buttons(out_buttons),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_LOW);
    clk = 1'b1;
    #(CLK_HIGH);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[ps2_mouse_packet_decoder] ERROR");
    $finish;
  end

  function automatic logic [COORD_W-1:0] clamp_to_screen(input int pos,
                                                         input logic [SIZE_W-1:0] size_reg);
    int lim;
    lim = int'(size_reg);
    // A zero size behaves as one pixel, anything past the coordinate range as the maximum.
    if (lim == 0) lim = 1;
    if (lim > MAX_SCREEN) lim = MAX_SCREEN;
    if (pos < 0) pos = 0;
    if (pos >= lim) pos = lim - 1;
    return pos[COORD_W-1:0];
  endfunction

  task automatic track_mouse_byte(input logic [BYTE_W-1:0] b);
    int nx;
    int ny;
    result_t move;
    case (pkt_pos)
      POS_X: begin
        pkt_xlow = b;
        pkt_pos = POS_Y;
      end
      POS_Y: begin
        pkt_pos = POS_FLAG;
        if (pkt_flag[FLAG_XOVF_BIT] || pkt_flag[FLAG_YOVF_BIT]) begin
          overflow_drops++;
        end else begin
          nx = int'(cur_x) + int'($signed({pkt_flag[FLAG_XSIGN_BIT], pkt_xlow}));
          // Screen rows grow downward, so the mouse Y movement is subtracted.
          ny = int'(cur_y) - int'($signed({pkt_flag[FLAG_YSIGN_BIT], b}));
          cur_x = clamp_to_screen(nx, scr_w);
          cur_y = clamp_to_screen(ny, scr_h);
          move.cursor_x = cur_x;
          move.cursor_y = cur_y;
          move.buttons = pkt_flag[BTN_W-1:0];
          pending_moves.push_back(move);
          moves_predicted++;
        end
      end
      default: begin
        if (b[FLAG_SYNC_BIT]) begin
          pkt_flag = b;
          pkt_pos = POS_X;
        end else begin
          resync_drops++;
        end
      end
    endcase
  endtask

  // Receiver: a long hold request wins over the current stall mode.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        STALL_PATTERN: begin
          out_stall <= STALL_PATTERN_BITS[pattern_step];
          pattern_step = (pattern_step + 1) % 11;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Inputs only move at rising edges, so a beat seen here is taken at the next edge.
  always @(negedge clk) begin : check_beat
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_moves.size() == 0) begin
        $error("unexpected result beat: cursor_x=%0d cursor_y=%0d buttons=%0d",
               out_cursor_x, out_cursor_y, out_buttons);
        err_count++;
      end else begin
        want = pending_moves.pop_front();
        moves_checked++;
        if (out_cursor_x !== want.cursor_x) begin
          $error("cursor_x mismatch: expected %0d, got %0d", want.cursor_x, out_cursor_x);
          err_count++;
        end
        if (out_cursor_y !== want.cursor_y) begin
          $error("cursor_y mismatch: expected %0d, got %0d", want.cursor_y, out_cursor_y);
          err_count++;
        end
        if (out_buttons !== want.buttons) begin
          $error("buttons mismatch: expected %0d, got %0d", want.buttons, out_buttons);
          err_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap_len;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len = $urandom_range(0, 6);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    track_mouse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [BTN_W-1:0] btn, input int dx, input int dy,
                             input logic [1:0] ovf);
    logic [BYTE_W-1:0] flag;
    logic [8:0] dx9;
    logic [8:0] dy9;
    dx9 = dx[8:0];
    dy9 = dy[8:0];
    flag = '0;
    flag[BTN_W-1:0] = btn;
    flag[FLAG_SYNC_BIT] = 1'b1;
    flag[FLAG_XSIGN_BIT] = dx9[8];
    flag[FLAG_YSIGN_BIT] = dy9[8];
    flag[FLAG_XOVF_BIT] = ovf[0];
    flag[FLAG_YOVF_BIT] = ovf[1];
    send_byte(flag);
    send_byte(dx9[7:0]);
    send_byte(dy9[7:0]);
  endtask

  function automatic int random_delta();
    if ($urandom_range(0, 1) != 0) return int'($urandom_range(0, 32)) - 16;
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  task automatic send_random_packet();
    logic [1:0] ovf;
    ovf = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    send_packet(BTN_W'($urandom_range(0, 7)), random_delta(), random_delta(), ovf);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_receiver(input stall_mode_t mode);
    in_valid <= 1'b0;
    @(negedge clk);
    stall_mode = mode;
    @(posedge clk);
  endtask

  task automatic hold_receiver(input int cycles);
    in_valid <= 1'b0;
    @(negedge clk);
    hold_req = cycles;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if (idx == REG_SCREEN_WIDTH) scr_w = data;
    else scr_h = data;
  endtask

  // The screen is only resized once the decoder has gone quiet.
  task automatic set_screen(input int w, input int h);
    wait_for_results();
    write_reg(REG_SCREEN_WIDTH, SIZE_W'(w));
    write_reg(REG_SCREEN_HEIGHT, SIZE_W'(h));
    cfg_valid <= 1'b0;
    screens_used++;
  endtask

  task automatic test_directed();
    logic [BYTE_W-1:0] seq[26];
    seq = '{8'h00, 8'hF7,               // bytes without the sync bit are dropped
            8'h08, 8'h00, 8'h00,
            8'h0F, 8'hFF, 8'hFF,
            8'h3F, 8'h00, 8'h00,        // most negative movement on both axes
            8'h48, 8'h10, 8'h10,
            8'h88, 8'h10, 8'h10,
            8'hFF, 8'hFF, 8'hFF,
            8'h1A, 8'h01, 8'h80,
            8'h0C, 8'h7F, 8'h81};
    gaps_on = 1'b1;
    set_receiver(STALL_PATTERN);
    foreach (seq[i]) send_byte(seq[i]);
    wait_for_results();
  endtask

  task automatic test_screen_sizes();
    set_receiver(STALL_RANDOM);
    set_screen(0, 0);
    repeat (15) send_random_packet();
    set_screen(1, 1);
    repeat (15) send_random_packet();
    set_screen(CFG_DATA_MAX, CFG_DATA_MAX);
    repeat (15) send_random_packet();
    set_screen(MAX_SCREEN, MAX_SCREEN);
    // Run the cursor into the bottom right corner, then shrink the screen under it.
    repeat (20) send_packet(BTN_W'($urandom_range(0, 7)), 255, -256, 2'b00);
    set_screen(100, 50);
    repeat (5) send_packet(BTN_W'($urandom_range(0, 7)), 0, 0, 2'b00);
    repeat (15) send_random_packet();
    set_screen(MAX_SCREEN - 1, 1);
    repeat (15) send_random_packet();
    set_screen(1, MAX_SCREEN + 1);
    repeat (15) send_random_packet();
    set_screen($urandom_range(0, CFG_DATA_MAX), $urandom_range(0, CFG_DATA_MAX));
    repeat (15) send_random_packet();
    set_screen(SCREEN_W_RST, SCREEN_H_RST);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int stop_at;
    int r;
    logic [BYTE_W-1:0] b;
    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase % 2 == 0);
      case (phase)
        1: set_receiver(STALL_OFF);
        2: set_receiver(STALL_PATTERN);
        default: set_receiver(STALL_RANDOM);
      endcase
      stop_at = bytes_sent + n_bytes / 4;
      while (bytes_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_random_packet();
        end else if (r < 90) begin
          send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
          // A cut-off packet shifts the byte alignment of what follows.
          b = BYTE_W'($urandom_range(0, 255));
          b[FLAG_SYNC_BIT] = 1'b1;
          send_byte(b);
          send_byte(BYTE_W'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    set_receiver(STALL_OFF);
    hold_receiver(HOLD_CYCLES);
    repeat (30) send_random_packet();
    wait_for_results();
    gaps_on = 1'b1;
    set_receiver(STALL_PATTERN);
    repeat (10) send_random_packet();
  endtask

  initial begin
    pkt_pos = POS_FLAG;
    pkt_flag = '0;
    pkt_xlow = '0;
    scr_w = SCREEN_W_RST;
    scr_h = SCREEN_H_RST;
    cur_x = SCREEN_W_RST[SIZE_W-1:1];
    cur_y = SCREEN_H_RST[SIZE_W-1:1];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_screen_sizes();
    test_random_traffic(640);
    test_backpressure();
    wait_for_results();

    $display("Sent %0d mouse bytes under %0d screen sizes; %0d cursor updates checked.",
             bytes_sent, screens_used, moves_checked);
    $display("Dropped as expected: %0d unsynced bytes, %0d overflowed packets.",
             resync_drops, overflow_drops);
    if (err_count == 0) begin
      $display("[ps2_mouse_packet_decoder] OK");
    end else begin
      $display("[ps2_mouse_packet_decoder] ERROR");
    end
    $finish;
  end

endmodule
